// ===== rtl/lpsd_pkg.sv =====
package lpsd_pkg;

    localparam int SEQ_W = 64;
    localparam int LEN_W = 16;

    localparam logic [7:0] TYPE_LOGIN = 8'h41;
    localparam logic [7:0] TYPE_SEQ   = 8'h53;
    localparam logic [7:0] TYPE_UNSEQ = 8'h55;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // sequence field of a login accepted packet, payload offsets
    localparam int SEQ_FIELD_OFFSET = 10;
    localparam int SEQ_FIELD_SIZE   = 20;
    localparam int SEQ_FIELD_END    = SEQ_FIELD_OFFSET + SEQ_FIELD_SIZE;
    localparam int IDX_W            = $clog2(SEQ_FIELD_END + 1);

    typedef enum logic [1:0] {
        KIND_SEQ   = 2'd0,
        KIND_UNSEQ = 2'd1,
        KIND_EVENT = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        PH_LEN_HI  = 4'b0001,
        PH_LEN_LO  = 4'b0010,
        PH_TYPE    = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        PS_SPACES = 3'b001,
        PS_DIGITS = 3'b010,
        PS_DONE   = 3'b100
    } t_pstage;

    typedef struct packed {
        logic       clear;
        logic       take;
        logic [7:0] ch;
    } t_parse_ctl;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       ptype;
        logic [7:0]       pbyte;
        logic             bvalid;
        logic             first;
        logic             last;
        logic [SEQ_W-1:0] seq;
    } t_result;

    function automatic t_kind kind_of(input logic [7:0] t);
        t_kind k;
        if (t == TYPE_SEQ) begin
            k = KIND_SEQ;
        end else if (t == TYPE_UNSEQ) begin
            k = KIND_UNSEQ;
        end else begin
            k = KIND_EVENT;
        end
        return k;
    endfunction

endpackage

// ===== rtl/lpsd_parse.sv =====
module lpsd_parse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpsd_pkg::t_parse_ctl          i_ctl,
    output logic [lpsd_pkg::SEQ_W-1:0]    o_load_seq
);
    import lpsd_pkg::*;

    t_pstage          r_stage, n_stage;
    logic [SEQ_W-1:0] r_val, n_val;
    logic             r_ovf, n_ovf;

    logic             digit;
    logic             acc;
    logic [SEQ_W+3:0] wide_val;
    logic [SEQ_W+3:0] prod;

    assign digit    = (i_ctl.ch >= CHAR_ZERO) && (i_ctl.ch <= CHAR_NINE);
    assign wide_val = {4'b0, r_val};
    // val*10 + d; anything above bit 63 is an overflow
    assign prod     = (wide_val << 3) + (wide_val << 1)
                      + (SEQ_W+4)'(i_ctl.ch[3:0]);

    always_comb begin
        n_stage = r_stage;
        n_val   = r_val;
        n_ovf   = r_ovf;
        acc     = 1'b0;
        if (i_ctl.clear) begin
            n_stage = PS_SPACES;
            n_val   = '0;
            n_ovf   = 1'b0;
        end else if (i_ctl.take) begin
            case (r_stage)
                PS_SPACES: begin
                    if (i_ctl.ch != CHAR_SPACE) begin
                        if (digit) begin
                            n_stage = PS_DIGITS;
                            acc     = 1'b1;
                        end else begin
                            n_stage = PS_DONE;
                        end
                    end
                end
                PS_DIGITS: begin
                    if (digit) begin
                        acc = 1'b1;
                    end else begin
                        n_stage = PS_DONE;
                    end
                end
                PS_DONE: begin
                    n_stage = PS_DONE;
                end
                default: begin
                    n_stage = PS_DONE;
                end
            endcase
            if (acc && !r_ovf) begin
                if (prod[SEQ_W+3:SEQ_W] != 4'd0) begin
                    n_ovf = 1'b1;
                end else begin
                    n_val = prod[SEQ_W-1:0];
                end
            end
        end
    end

    // value a completed login would load, including the word now taken
    assign o_load_seq = (n_ovf || (n_val == '0)) ? SEQ_W'(1) : n_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= PS_SPACES;
            r_val   <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_stage <= n_stage;
            r_val   <= n_val;
            r_ovf   <= n_ovf;
        end
    end

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf && !i_ctl.clear |=> r_ovf)
        else $error("overflow flag dropped without a clear");

endmodule

// ===== rtl/lpsd_frame.sv =====
module lpsd_frame (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [7:0]                    i_byte,
    input  logic                          i_cfg_we,
    input  logic [lpsd_pkg::SEQ_W-1:0]    i_cfg_data,
    input  logic [lpsd_pkg::SEQ_W-1:0]    i_load_seq,
    output lpsd_pkg::t_parse_ctl          o_pctl,
    output logic                          o_res_valid,
    output lpsd_pkg::t_result             o_res
);
    import lpsd_pkg::*;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_len_hi, n_len_hi;
    logic [LEN_W-1:0] r_left, n_left;
    logic [IDX_W-1:0] r_pidx, n_pidx;
    logic [7:0]       r_type, n_type;
    logic [SEQ_W-1:0] r_next_seq, n_next_seq;
    logic [SEQ_W-1:0] r_cur_seq, n_cur_seq;

    logic [LEN_W-1:0] len;
    logic             last;
    logic             in_field;

    assign len      = {r_len_hi, i_byte};
    assign last     = (r_left <= LEN_W'(1));
    assign in_field = (r_type == TYPE_LOGIN) && (r_pidx >= IDX_W'(SEQ_FIELD_OFFSET))
                      && (r_pidx < IDX_W'(SEQ_FIELD_END));

    assign o_pctl.clear = i_go && (r_phase == PH_TYPE);
    assign o_pctl.take  = i_go && (r_phase == PH_PAYLOAD) && in_field;
    assign o_pctl.ch    = i_byte;

    always_comb begin
        n_phase     = r_phase;
        n_len_hi    = r_len_hi;
        n_left      = r_left;
        n_pidx      = r_pidx;
        n_type      = r_type;
        n_next_seq  = r_next_seq;
        n_cur_seq   = r_cur_seq;
        o_res_valid = 1'b0;
        o_res.kind   = kind_of(r_type);
        o_res.ptype  = r_type;
        o_res.pbyte  = i_byte;
        o_res.bvalid = 1'b1;
        o_res.first  = (r_pidx == '0);
        o_res.last   = last;
        o_res.seq    = (kind_of(r_type) == KIND_SEQ) ? r_cur_seq : '0;
        if (i_go) begin
            case (r_phase)
                PH_LEN_HI: begin
                    n_len_hi = i_byte;
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (len == '0) begin
                        n_phase = PH_LEN_HI;
                    end else begin
                        n_left  = len - LEN_W'(1);
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_type = i_byte;
                    n_pidx = '0;
                    if (i_byte == TYPE_SEQ) begin
                        n_cur_seq  = r_next_seq;
                        n_next_seq = r_next_seq + SEQ_W'(1);
                    end
                    if (r_left == '0) begin
                        n_phase = PH_LEN_HI;
                        // empty event packet: one word without a byte
                        o_res_valid  = (kind_of(i_byte) == KIND_EVENT);
                        o_res.kind   = KIND_EVENT;
                        o_res.ptype  = i_byte;
                        o_res.pbyte  = '0;
                        o_res.bvalid = 1'b0;
                        o_res.first  = 1'b1;
                        o_res.last   = 1'b1;
                        o_res.seq    = '0;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    o_res_valid = 1'b1;
                    n_pidx = (r_pidx == IDX_W'(SEQ_FIELD_END)) ? r_pidx
                                                             : r_pidx + IDX_W'(1);
                    n_left = last ? '0 : r_left - LEN_W'(1);
                    if (last) begin
                        n_phase = PH_LEN_HI;
                        if ((r_type == TYPE_LOGIN) &&
                            (r_pidx >= IDX_W'(SEQ_FIELD_END - 1))) begin
                            n_next_seq = i_load_seq;
                        end
                    end
                end
                default: begin
                    n_phase = PH_LEN_HI;
                end
            endcase
        end
        if (i_cfg_we) begin
            n_next_seq = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEN_HI;
            r_len_hi   <= '0;
            r_left     <= '0;
            r_pidx     <= '0;
            r_type     <= '0;
            r_next_seq <= SEQ_W'(1);
            r_cur_seq  <= '0;
        end else begin
            r_phase    <= n_phase;
            r_len_hi   <= n_len_hi;
            r_left     <= n_left;
            r_pidx     <= n_pidx;
            r_type     <= n_type;
            r_next_seq <= n_next_seq;
            r_cur_seq  <= n_cur_seq;
        end
    end

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_left != '0)
        else $error("payload phase with no bytes left");

    a_empty_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.bvalid |-> o_res.first && o_res.last)
        else $error("byteless word not marked first and last");

    a_seq_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && r_phase == PH_TYPE && i_byte == TYPE_SEQ && !i_cfg_we
        |=> r_next_seq == $past(r_next_seq) + SEQ_W'(1) && r_cur_seq == $past(r_next_seq))
        else $error("sequenced packet did not take and advance the sequence");

endmodule

// ===== rtl/length_prefixed_session_deframer_unit.sv =====
// Channel  Handshake                   Payload
// -------  --------------------------  ------------------------------------------
// in       i_in_valid / o_in_ready     i_data_byte
// out      o_out_valid / i_out_ready   o_kind o_packet_type o_payload_byte
//                                      o_byte_valid o_first_byte o_last_byte
//                                      o_message_sequence
// cfg      i_cfg_we                    i_cfg_data (start sequence)
//
// One word per cycle sustained while the result is not held. A byte waits in the input register,
// then framing and sequence parse update in a single pass into the result register.
// Synchronous active-low reset; next sequence resets to 1, no clearing pass.
// A held result stalls the input stage; the input register still fills if it is empty.
module length_prefixed_session_deframer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_cfg_we,
    input  logic [lpsd_pkg::SEQ_W-1:0]    i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_kind,
    output logic [7:0]                    o_packet_type,
    output logic [7:0]                    o_payload_byte,
    output logic                          o_byte_valid,
    output logic                          o_first_byte,
    output logic                          o_last_byte,
    output logic [lpsd_pkg::SEQ_W-1:0]    o_message_sequence
);
    import lpsd_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    t_result          r_res;

    logic             go;
    logic             res_valid;
    t_result          res;
    t_parse_ctl       pctl;
    logic [SEQ_W-1:0] load_seq;

    // stage advances when it holds a byte and the result register can take a word
    assign go         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || go;

    lpsd_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (pctl),
        .o_load_seq (load_seq)
    );

    lpsd_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_byte      (r_in_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_load_seq  (load_seq),
        .o_pctl      (pctl),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (go) begin
                r_out_valid <= res_valid;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
        if (go && res_valid) begin
            r_res <= res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_kind             = r_res.kind;
    assign o_packet_type      = r_res.ptype;
    assign o_payload_byte     = r_res.pbyte;
    assign o_byte_valid       = r_res.bvalid;
    assign o_first_byte       = r_res.first;
    assign o_last_byte        = r_res.last;
    assign o_message_sequence = r_res.seq;

endmodule

// ===== test/lpsd_deframe_checker.sv =====
module lpsd_deframe_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_cfg_we,
    input  logic [lpsd_pkg::SEQ_W-1:0] i_cfg_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [1:0]                 i_kind,
    input  logic [7:0]                 i_packet_type,
    input  logic [7:0]                 i_payload_byte,
    input  logic                       i_byte_valid,
    input  logic                       i_first_byte,
    input  logic                       i_last_byte,
    input  logic [lpsd_pkg::SEQ_W-1:0] i_message_sequence,
    output int                         o_fail_count,
    output int                         o_pending
);
    import lpsd_pkg::*;

    // framing and sequence tracking, mirrored from the stream
    t_phase           frame_phase;
    logic [7:0]       len_hi;
    logic [15:0]      remaining;
    logic [15:0]      pay_idx;
    logic [7:0]       cur_type;
    logic [SEQ_W-1:0] next_seq;
    logic [SEQ_W-1:0] cur_seq;
    logic [SEQ_W-1:0] seq_accum;
    t_pstage          digit_stage;
    logic             seq_ovf;

    t_result          pending_results [$];
    t_result          want;
    t_result          fresh;
    logic             produced;
    int               mismatches = 0;
    int               results_seen = 0;

    assign o_fail_count = mismatches;

    function automatic t_kind classify_type(input logic [7:0] t);
        if (t == TYPE_SEQ) begin
            return KIND_SEQ;
        end else if (t == TYPE_UNSEQ) begin
            return KIND_UNSEQ;
        end
        return KIND_EVENT;
    endfunction

    function automatic t_result make_result(input logic [7:0] t, input logic [7:0] pb,
                                            input logic valid, input logic first,
                                            input logic last);
        t_result r;
        r.kind   = classify_type(t);
        r.ptype  = t;
        r.pbyte  = valid ? pb : 8'h00;
        r.bvalid = valid;
        r.first  = first;
        r.last   = last;
        r.seq    = (r.kind == KIND_SEQ) ? cur_seq : '0;
        return r;
    endfunction

    // one character of the login sequence field
    task automatic take_seq_char(input logic [7:0] c);
        logic             is_digit;
        logic [SEQ_W-1:0] d;
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        d = {56'd0, c - CHAR_ZERO};
        if (digit_stage == PS_SPACES) begin
            if (c == CHAR_SPACE) return;
            if (!is_digit) begin
                digit_stage = PS_DONE;
                return;
            end
            digit_stage = PS_DIGITS;
        end else if (digit_stage != PS_DIGITS) begin
            return;
        end
        if (!is_digit) begin
            digit_stage = PS_DONE;
            return;
        end
        if (seq_ovf || seq_accum > ({SEQ_W{1'b1}} - d) / 64'd10) begin
            seq_ovf = 1'b1;
        end else begin
            seq_accum = seq_accum * 64'd10 + d;
        end
    endtask

    task automatic deframe_word(input logic [7:0] b, output logic has_result,
                                output t_result r);
        logic [15:0] len;
        logic        first;
        logic        last;
        has_result = 1'b0;
        r = '0;
        case (frame_phase)
            PH_LEN_HI: begin
                len_hi = b;
                frame_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len = {len_hi, b};
                if (len == 16'd0) begin
                    frame_phase = PH_LEN_HI;
                end else begin
                    remaining = len - 16'd1;
                    frame_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                cur_type = b;
                pay_idx = '0;
                seq_accum = '0;
                digit_stage = PS_SPACES;
                seq_ovf = 1'b0;
                if (b == TYPE_SEQ) begin
                    cur_seq = next_seq;
                    next_seq = next_seq + 64'd1;
                end
                if (remaining == 16'd0) begin
                    frame_phase = PH_LEN_HI;
                    // only an event packet reports an empty body
                    if (classify_type(b) == KIND_EVENT) begin
                        has_result = 1'b1;
                        r = make_result(b, 8'h00, 1'b0, 1'b1, 1'b1);
                    end
                end else begin
                    frame_phase = PH_PAYLOAD;
                end
            end
            default: begin
                first = (pay_idx == 16'd0);
                last = (remaining <= 16'd1);
                if (cur_type == TYPE_LOGIN && pay_idx >= SEQ_FIELD_OFFSET &&
                    pay_idx < SEQ_FIELD_END) begin
                    take_seq_char(b);
                end
                has_result = 1'b1;
                r = make_result(cur_type, b, 1'b1, first, last);
                pay_idx = pay_idx + 16'd1;
                remaining = last ? 16'd0 : remaining - 16'd1;
                if (last) begin
                    if (cur_type == TYPE_LOGIN && pay_idx >= SEQ_FIELD_END) begin
                        next_seq = (seq_ovf || seq_accum == '0) ? 64'd1 : seq_accum;
                    end
                    frame_phase = PH_LEN_HI;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [SEQ_W-1:0] got,
                                   input logic [SEQ_W-1:0] exp_v);
        mismatches++;
        $display("mismatch on %s at result %0d: got %0h, wanted %0h",
                 what, results_seen, got, exp_v);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_phase = PH_LEN_HI;
            len_hi = '0;
            remaining = '0;
            pay_idx = '0;
            cur_type = '0;
            next_seq = 64'd1;
            cur_seq = '0;
            seq_accum = '0;
            digit_stage = PS_SPACES;
            seq_ovf = 1'b0;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                next_seq = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected word", {56'd0, i_payload_byte}, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_kind !== want.kind)
                        report_mismatch("kind", i_kind, want.kind);
                    if (i_packet_type !== want.ptype)
                        report_mismatch("packet_type", i_packet_type, want.ptype);
                    if (i_payload_byte !== want.pbyte)
                        report_mismatch("payload_byte", i_payload_byte, want.pbyte);
                    if (i_byte_valid !== want.bvalid)
                        report_mismatch("byte_valid", i_byte_valid, want.bvalid);
                    if (i_first_byte !== want.first)
                        report_mismatch("first_byte", i_first_byte, want.first);
                    if (i_last_byte !== want.last)
                        report_mismatch("last_byte", i_last_byte, want.last);
                    if (i_message_sequence !== want.seq)
                        report_mismatch("message_sequence", i_message_sequence, want.seq);
                end
            end
            if (i_in_valid && i_in_ready) begin
                deframe_word(i_data_byte, produced, fresh);
                if (produced) pending_results.insert(pending_results.size(), fresh);
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

// ===== test/tb_length_prefixed_session_deframer_unit.sv =====
module tb_length_prefixed_session_deframer_unit;
    import lpsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_WORDS    = 200;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic [7:0]       data_byte = '0;
    logic             cfg_we = 1'b0;
    logic [SEQ_W-1:0] cfg_data = '0;
    logic             out_ready = 1'b0;
    logic             steady = 1'b0;

    wire              in_ready;
    wire              out_valid;
    wire [1:0]        kind;
    wire [7:0]        packet_type;
    wire [7:0]        payload_byte;
    wire              byte_valid;
    wire              first_byte;
    wire              last_byte;
    wire [SEQ_W-1:0]  message_sequence;
    int               fail_count;
    int               pending;

    logic [7:0]       frame_q [$];
    int               words_sent = 0;
    int               stall_cycles = 0;
    int               phase_base;

    always #5 clk = ~clk;

    length_prefixed_session_deframer_unit dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_data_byte        (data_byte),
        .i_cfg_we           (cfg_we),
        .i_cfg_data         (cfg_data),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_kind             (kind),
        .o_packet_type      (packet_type),
        .o_payload_byte     (payload_byte),
        .o_byte_valid       (byte_valid),
        .o_first_byte       (first_byte),
        .o_last_byte        (last_byte),
        .o_message_sequence (message_sequence)
    );

    lpsd_deframe_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_data_byte        (data_byte),
        .i_cfg_we           (cfg_we),
        .i_cfg_data         (cfg_data),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_kind             (kind),
        .i_packet_type      (packet_type),
        .i_payload_byte     (payload_byte),
        .i_byte_valid       (byte_valid),
        .i_first_byte       (first_byte),
        .i_last_byte        (last_byte),
        .i_message_sequence (message_sequence),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    always @(posedge clk) begin
        out_ready <= steady || ($urandom_range(0, 99) >= 21);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // valid stays up between back-to-back words; it drops only for a gap
    task automatic send_word(input logic [7:0] b);
        while (!steady && $urandom_range(0, 99) < 21) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_frame();
        while (frame_q.size() != 0) send_word(frame_q.pop_front());
    endtask

    task automatic wait_drained(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_start_seq(input logic [SEQ_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_header(input logic [15:0] len, input logic [7:0] t);
        frame_q.insert(frame_q.size(), len[15:8]);
        frame_q.insert(frame_q.size(), len[7:0]);
        if (len != 16'd0) frame_q.insert(frame_q.size(), t);
    endtask

    task automatic add_plain(input logic [7:0] t, input int n);
        add_header(16'(n + 1), t);
        repeat (n) frame_q.insert(frame_q.size(), 8'($urandom_range(0, 255)));
    endtask

    task automatic add_login(input int n);
        logic [7:0] field [20];
        logic [7:0] c;
        string      max_txt;
        int         mode;
        int         k;
        int         m;
        max_txt = "18446744073709551615";
        mode = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 7);
        for (int i = 0; i < 20; i++) field[i] = 8'($urandom_range(0, 255));
        case (mode)
            0: begin
                k = $urandom_range(0, 8);
                m = $urandom_range(1, 12);
                for (int i = 0; i < 20; i++) begin
                    if (i < k) begin
                        field[i] = CHAR_SPACE;
                    end else if (i < k + m) begin
                        field[i] = CHAR_ZERO + 8'($urandom_range(0, 9));
                    end else if (i == k + m) begin
                        do c = 8'($urandom_range(0, 255));
                        while (c >= CHAR_ZERO && c <= CHAR_NINE);
                        field[i] = ($urandom_range(0, 1) == 0) ? CHAR_SPACE : c;
                    end
                end
            end
            1: begin
                // zero value falls back to one
                k = $urandom_range(0, 6);
                for (int i = 0; i < 20; i++)
                    field[i] = (i < k || i >= k + 5) ? CHAR_SPACE : CHAR_ZERO;
            end
            2: begin
                for (int i = 0; i < 20; i++) field[i] = CHAR_SPACE;
            end
            3: begin
                for (int i = 0; i < 20; i++) field[i] = max_txt[i];
            end
            4: begin
                // one past the 64-bit maximum
                for (int i = 0; i < 20; i++) field[i] = max_txt[i];
                field[19] = CHAR_ZERO + 8'd6;
            end
            5: begin
                for (int i = 0; i < 20; i++) field[i] = CHAR_ZERO + 8'($urandom_range(0, 9));
            end
            7: begin
                field[0] = TYPE_LOGIN + 8'($urandom_range(0, 25));
                for (int i = 1; i < 20; i++) field[i] = CHAR_ZERO + 8'($urandom_range(0, 9));
            end
            default: begin
            end
        endcase
        add_header(16'(n + 1), TYPE_LOGIN);
        for (int i = 0; i < n; i++) begin
            if (i >= SEQ_FIELD_OFFSET && i < SEQ_FIELD_END)
                frame_q.insert(frame_q.size(), field[i - SEQ_FIELD_OFFSET]);
            else
                frame_q.insert(frame_q.size(), 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic add_random_frame();
        int         sel;
        logic [7:0] t;
        sel = $urandom_range(0, 99);
        if (sel < 6) begin
            add_header(16'd0, TYPE_SEQ);
        end else if (sel < 34) begin
            add_plain(TYPE_SEQ, $urandom_range(0, 10));
        end else if (sel < 52) begin
            add_plain(TYPE_UNSEQ, $urandom_range(0, 10));
        end else if (sel < 67) begin
            add_login($urandom_range(30, 40));
        end else if (sel < 72) begin
            add_login($urandom_range(0, 29));
        end else if (sel < 84) begin
            add_plain(8'($urandom_range(0, 255)), $urandom_range(0, 6));
        end else if (sel < 90) begin
            add_plain(8'($urandom_range(0, 255)), 0);
        end else if (sel < 93) begin
            case ($urandom_range(0, 2))
                0: t = TYPE_SEQ;
                1: t = TYPE_UNSEQ;
                default: t = 8'($urandom_range(0, 255));
            endcase
            add_plain(t, $urandom_range(240, 300));
        end else begin
            // run of short sequenced packets, empty ones included
            repeat ($urandom_range(2, 6)) add_plain(TYPE_SEQ, $urandom_range(0, 1));
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // skipped frame, empty login, empty data packets, unknown types, byte extremes
        frame_q = '{8'h00, 8'h00,
                    8'h00, 8'h01, TYPE_LOGIN,
                    8'h00, 8'h01, TYPE_SEQ,
                    8'h00, 8'h01, TYPE_UNSEQ,
                    8'h00, 8'h02, TYPE_SEQ, 8'hFF,
                    8'h00, 8'h03, TYPE_UNSEQ, 8'h00, 8'h80,
                    8'h00, 8'h02, 8'h00, 8'h7F,
                    8'h00, 8'h01, 8'hFF};
        send_frame();

        for (int p = 0; p < 4; p++) begin
            wait_drained(SETTLE_CYCLES);
            case (p)
                0: write_start_seq('0);
                1: write_start_seq('1);
                2: write_start_seq({$urandom, $urandom});
                default: write_start_seq(64'hFFFF_FFFF_FFFF_FFFD);
            endcase
            phase_base = words_sent;
            if (p == 2) steady <= 1'b1;
            while (words_sent - phase_base < PHASE_WORDS) begin
                add_random_frame();
                send_frame();
                if (words_sent - phase_base > 150) steady <= 1'b0;
                if ($urandom_range(0, 29) == 0) wait_drained(0);
            end
            steady <= 1'b0;
        end

        wait_drained(SETTLE_CYCLES + 4);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
